// ----- rtl/mtq_pkg.sv -----
// Package for the max tracking queue: value and result types, operation and
// status codes, stack control structs and the signed max helper.
// No dependencies.
package mtq_pkg;

  localparam int VAL_W     = 32;
  localparam int DEPTH_DEF = 128;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic {
    FN_ENQ = 1'b0,
    FN_DEQ = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DEQ_EMPTY = 2'd1,
    ST_ENQ_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,
    CELL_POP  = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic push;
    logic pop;
    val_t val;
    val_t max;
  } stk_ctrl_t;

  typedef struct packed {
    val_t top_val;
    val_t top_max;
    logic empty;
  } stk_stat_t;

  typedef struct packed {
    val_t    popped_value;
    val_t    queue_max;
    logic    is_empty;
    status_t status;
  } result_t;

  function automatic val_t smax(input val_t a, input val_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- rtl/mtq_in_if.sv -----
// Command channel interface: valid/ready plus operation and value.
// Depends on mtq_pkg.
interface mtq_in_if;
  import mtq_pkg::*;

  logic valid;
  logic ready;
  logic func;
  val_t value;

  modport source(output valid, output func, output value, input ready);
  modport sink(input valid, input func, input value, output ready);
endinterface

// ----- rtl/mtq_out_if.sv -----
// Result channel interface: valid/ready plus popped value, max, empty flag
// and status. Depends on mtq_pkg.
interface mtq_out_if;
  import mtq_pkg::*;

  logic       valid;
  logic       ready;
  val_t       popped_value;
  val_t       queue_max;
  logic       is_empty;
  logic [1:0] status;

  modport source(output valid, output popped_value, output queue_max,
                 output is_empty, output status, input ready);
  modport sink(input valid, input popped_value, input queue_max,
               input is_empty, input status, output ready);
endinterface

// ----- rtl/mtq_cell.sv -----
// One stack cell: holds a value and its running max; shifts in from the
// upper neighbor on push and from the lower neighbor on pop. Uses mtq_pkg.
module mtq_cell (
  input  logic             clk,
  input  mtq_pkg::cell_op_t op,
  input  mtq_pkg::val_t    left_val,
  input  mtq_pkg::val_t    left_max,
  input  mtq_pkg::val_t    right_val,
  input  mtq_pkg::val_t    right_max,
  output mtq_pkg::val_t    val,
  output mtq_pkg::val_t    max
);
  import mtq_pkg::*;

  always_ff @(posedge clk) begin
    case (op)
      CELL_PUSH: begin
        val <= left_val;
        max <= left_max;
      end
      CELL_POP: begin
        val <= right_val;
        max <= right_max;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/mtq_stack.sv -----
// Shift stack built from a row of mtq_cell; cell 0 is the top.
// Keeps the fill count. Uses mtq_pkg, instantiates mtq_cell.
module mtq_stack #(
  parameter int DEPTH = mtq_pkg::DEPTH_DEF,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  mtq_pkg::stk_ctrl_t ctrl,
  output mtq_pkg::stk_stat_t stat,
  output logic [CW-1:0]      count
);
  import mtq_pkg::*;

  cell_op_t op;
  val_t     cval [DEPTH];
  val_t     cmax [DEPTH];

  always_comb begin
    if (ctrl.push) begin
      op = CELL_PUSH;
    end else if (ctrl.pop) begin
      op = CELL_POP;
    end else begin
      op = CELL_HOLD;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    val_t lv, lm, rv, rm;
    if (i == 0) begin : g_first
      assign lv = ctrl.val;
      assign lm = ctrl.max;
    end else begin : g_mid_l
      assign lv = cval[i-1];
      assign lm = cmax[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rv = MOST_NEG;
      assign rm = MOST_NEG;
    end else begin : g_mid_r
      assign rv = cval[i+1];
      assign rm = cmax[i+1];
    end
    mtq_cell u_cell (
      .clk      (clk),
      .op       (op),
      .left_val (lv),
      .left_max (lm),
      .right_val(rv),
      .right_max(rm),
      .val      (cval[i]),
      .max      (cmax[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.push) begin
      count <= count + 1'b1;
    end else if (ctrl.pop) begin
      count <= count - 1'b1;
    end
  end

  always_comb begin
    stat.empty   = (count == '0);
    stat.top_val = cval[0];
    stat.top_max = stat.empty ? MOST_NEG : cmax[0];
  end

endmodule

// ----- rtl/max_tracking_queue.sv -----
// Channel | dir | payload                                   | handshake
// cmd     | in  | func, value                               | valid/ready
// res     | out | popped_value, queue_max, is_empty, status | valid/ready
//
// Enqueue and rejected ops finish in S_IDLE. Dequeue with a filled output stack
// pops in S_IDLE and reports in S_FIN. Dequeue with an empty output stack first
// moves one value per cycle through the two cell chains in S_MOVE, then S_POP, S_FIN.
// Reset (rst, synchronous) empties both stacks and the result buffers.
// A stalled result lets one more op in; its result waits in a spare buffer.
// Top level: two mtq_stack instances and the control FSM. Uses mtq_pkg,
// mtq_in_if and mtq_out_if.
module max_tracking_queue #(
  parameter int DEPTH = mtq_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  mtq_in_if.sink     cmd,
  mtq_out_if.source  res
);
  import mtq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOVE = 4'b0010,
    S_POP  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t        state, state_next;
  stk_ctrl_t     in_ctrl, out_ctrl;
  stk_stat_t     in_stat, out_stat;
  logic [CW-1:0] in_count, out_count;
  logic [CW:0]   total;
  logic          full, empty_now, accept;
  val_t          enq_max, pop_val;
  result_t       emit_res, pend, out_reg;
  logic          emit, pend_valid, out_valid, out_free;

  mtq_stack #(.DEPTH(DEPTH)) u_in_stk (
    .clk  (clk),
    .rst  (rst),
    .ctrl (in_ctrl),
    .stat (in_stat),
    .count(in_count)
  );

  mtq_stack #(.DEPTH(DEPTH)) u_out_stk (
    .clk  (clk),
    .rst  (rst),
    .ctrl (out_ctrl),
    .stat (out_stat),
    .count(out_count)
  );

  assign total     = {1'b0, in_count} + {1'b0, out_count};
  assign full      = (total >= (CW+1)'(DEPTH));
  assign empty_now = in_stat.empty && out_stat.empty;
  assign enq_max   = smax(cmd.value, in_stat.top_max);
  assign cmd.ready = (state == S_IDLE) && !pend_valid;
  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !out_valid || res.ready;

  always_comb begin
    in_ctrl    = '0;
    out_ctrl   = '0;
    emit       = 1'b0;
    emit_res   = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd.func == FN_ENQ) begin
            emit = 1'b1;
            if (full) begin
              emit_res.queue_max = smax(in_stat.top_max, out_stat.top_max);
              emit_res.is_empty  = empty_now;
              emit_res.status    = ST_ENQ_FULL;
            end else begin
              in_ctrl.push       = 1'b1;
              in_ctrl.val        = cmd.value;
              in_ctrl.max        = enq_max;
              emit_res.queue_max = smax(enq_max, out_stat.top_max);
              emit_res.is_empty  = 1'b0;
              emit_res.status    = ST_DONE;
            end
          end else if (empty_now) begin
            emit               = 1'b1;
            emit_res.queue_max = MOST_NEG;
            emit_res.is_empty  = 1'b1;
            emit_res.status    = ST_DEQ_EMPTY;
          end else if (out_stat.empty) begin
            state_next = S_MOVE;
          end else begin
            out_ctrl.pop = 1'b1;
            state_next   = S_FIN;
          end
        end
      end
      S_MOVE: begin
        in_ctrl.pop   = 1'b1;
        out_ctrl.push = 1'b1;
        out_ctrl.val  = in_stat.top_val;
        out_ctrl.max  = smax(in_stat.top_val, out_stat.top_max);
        if (in_count == CW'(1)) begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        out_ctrl.pop = 1'b1;
        state_next   = S_FIN;
      end
      S_FIN: begin
        emit                  = 1'b1;
        emit_res.popped_value = pop_val;
        emit_res.queue_max    = smax(in_stat.top_max, out_stat.top_max);
        emit_res.is_empty     = empty_now;
        emit_res.status       = ST_DONE;
        state_next            = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_ctrl.pop) begin
      pop_val <= out_stat.top_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        if (out_free) begin
          out_valid <= 1'b1;
        end else begin
          pend_valid <= 1'b1;
        end
      end else if (pend_valid && out_free) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (out_free) begin
        out_reg <= emit_res;
      end else begin
        pend <= emit_res;
      end
    end else if (pend_valid && out_free) begin
      out_reg <= pend;
    end
  end

  assign res.valid        = out_valid;
  assign res.popped_value = out_reg.popped_value;
  assign res.queue_max    = out_reg.queue_max;
  assign res.is_empty     = out_reg.is_empty;
  assign res.status       = out_reg.status;

endmodule

// ----- rtl/mtq_checker.sv -----
// Port-level checks for max_tracking_queue, attached by bind.
// Uses mtq_pkg.
module mtq_checker (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_ready,
  input mtq_pkg::val_t       popped_value,
  input mtq_pkg::val_t       queue_max,
  input logic                is_empty,
  input logic [1:0]          status
);
  import mtq_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(popped_value) &&
      $stable(queue_max) && $stable(is_empty) && $stable(status))
    else $error("result changed while stalled");

  a_deq_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_DEQ_EMPTY |->
      is_empty && queue_max == MOST_NEG && popped_value == '0)
    else $error("bad dequeue-on-empty result");

  a_empty_max: assert property (@(posedge clk) disable iff (rst)
    res_valid && is_empty |-> queue_max == MOST_NEG)
    else $error("empty queue reports a max");

  a_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_ENQ_FULL |-> popped_value == '0 && !is_empty)
    else $error("bad enqueue-on-full result");

endmodule

bind max_tracking_queue mtq_checker u_mtq_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .popped_value(res.popped_value),
  .queue_max   (res.queue_max),
  .is_empty    (res.is_empty),
  .status      (res.status)
);

// ----- test/tb.sv -----
// Testbench for max_tracking_queue: directed and random enqueue/dequeue traffic
// checked against a two-stack queue model, with bursty sender and stalling receiver.
// Depends on mtq_pkg, mtq_in_if, mtq_out_if and the max_tracking_queue RTL.
module tb;
  import mtq_pkg::*;

  localparam int QDEPTH     = DEPTH_DEF;
  localparam int RAND_ITEMS = 1950;
  localparam int IDLE_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst;

  mtq_in_if  cmd ();
  mtq_out_if res ();

  max_tracking_queue #(.DEPTH(QDEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .res(res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // queue model: input and output stacks, each entry with its running max
  val_t in_vals  [QDEPTH];
  val_t in_maxs  [QDEPTH];
  val_t out_vals [QDEPTH];
  val_t out_maxs [QDEPTH];
  int   in_cnt;
  int   out_cnt;

  result_t pending_replies[$];
  int      err_count;
  int      idle_cycles;
  int      burst_left;

  function automatic result_t queue_op_reply(input func_t f, input val_t v);
    result_t r;
    val_t    top_in;
    val_t    top_out;
    r.popped_value = '0;
    r.status       = ST_DONE;
    if (f == FN_ENQ) begin
      if (in_cnt + out_cnt >= QDEPTH) begin
        r.status = ST_ENQ_FULL;
      end else begin
        if (in_cnt == 0 || v > in_maxs[in_cnt-1]) in_maxs[in_cnt] = v;
        else in_maxs[in_cnt] = in_maxs[in_cnt-1];
        in_vals[in_cnt] = v;
        in_cnt++;
      end
    end else begin
      if (in_cnt + out_cnt == 0) begin
        r.status = ST_DEQ_EMPTY;
      end else begin
        if (out_cnt == 0) begin
          while (in_cnt > 0) begin
            in_cnt--;
            if (out_cnt == 0 || in_vals[in_cnt] > out_maxs[out_cnt-1])
              out_maxs[out_cnt] = in_vals[in_cnt];
            else
              out_maxs[out_cnt] = out_maxs[out_cnt-1];
            out_vals[out_cnt] = in_vals[in_cnt];
            out_cnt++;
          end
        end
        out_cnt--;
        r.popped_value = out_vals[out_cnt];
      end
    end
    top_in  = (in_cnt == 0)  ? MOST_NEG : in_maxs[in_cnt-1];
    top_out = (out_cnt == 0) ? MOST_NEG : out_maxs[out_cnt-1];
    r.queue_max = (top_in > top_out) ? top_in : top_out;
    r.is_empty  = (in_cnt + out_cnt == 0);
    return r;
  endfunction

  // transaction monitor, result checker and watchdog
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (cmd.valid && cmd.ready)
        pending_replies.push_back(queue_op_reply(func_t'(cmd.func), cmd.value));
      if (res.valid && res.ready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected result popped=%0d max=%0d empty=%0b status=%0d",
                   $time, res.popped_value, res.queue_max, res.is_empty, res.status);
          err_count++;
        end else begin
          want = pending_replies.pop_front();
          if (res.popped_value !== want.popped_value) begin
            $display("%0t: popped_value expected %0d actual %0d",
                     $time, want.popped_value, res.popped_value);
            err_count++;
          end
          if (res.queue_max !== want.queue_max) begin
            $display("%0t: queue_max expected %0d actual %0d",
                     $time, want.queue_max, res.queue_max);
            err_count++;
          end
          if (res.is_empty !== want.is_empty) begin
            $display("%0t: is_empty expected %0b actual %0b",
                     $time, want.is_empty, res.is_empty);
            err_count++;
          end
          if (res.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, res.status);
            err_count++;
          end
        end
      end
      if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // receiver: stall pattern picks a new random mode after each random-length phase
  initial begin
    int mode;
    int phase_left;
    int tick;
    res.ready  = 1'b0;
    phase_left = 0;
    tick       = 0;
    mode       = 0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 3);
        phase_left = $urandom_range(8, 80);
      end
      phase_left--;
      tick++;
      case (mode)
        0:       res.ready <= 1'b1;
        1:       res.ready <= 1'($urandom_range(0, 1));
        2:       res.ready <= (tick % 5) != 0;
        default: res.ready <= (tick % 7) < 2;
      endcase
    end
  end

  function automatic val_t rand_value();
    case ($urandom_range(0, 7))
      0:       return MOST_NEG;
      1:       return val_t'(32'h7fff_ffff);
      2, 3:    return val_t'(int'($urandom_range(0, 16)) - 8);
      default: return val_t'($urandom);
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send_op(input func_t f, input val_t v);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(20, 60);
      end else begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 24);
      end
      if (gap > 0) begin
        cmd.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    cmd.valid <= 1'b1;
    cmd.func  <= f;
    cmd.value <= v;
    do @(posedge clk); while (!cmd.ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic test_empty_dequeue();
    send_op(FN_DEQ, val_t'(32'h1234_5678));
    send_op(FN_DEQ, MOST_NEG);
  endtask

  task automatic test_extremes();
    send_op(FN_ENQ, MOST_NEG);
    send_op(FN_ENQ, val_t'(32'h7fff_ffff));
    send_op(FN_ENQ, val_t'(-1));
    send_op(FN_ENQ, val_t'(0));
    send_op(FN_ENQ, val_t'(1));
    repeat (6) send_op(FN_DEQ, val_t'(32'hffff_ffff));
  endtask

  task automatic test_interleave();
    send_op(FN_ENQ, val_t'(5));
    send_op(FN_ENQ, val_t'(9));
    send_op(FN_ENQ, val_t'(-3));
    send_op(FN_DEQ, val_t'(0));
    send_op(FN_ENQ, val_t'(9));
    send_op(FN_ENQ, val_t'(2));
    repeat (4) send_op(FN_DEQ, val_t'(0));
  endtask

  task automatic test_random();
    int sent;
    int kind;
    int len;
    int enq_pct;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // fill to capacity, then push past it
        while (in_cnt + out_cnt < QDEPTH) begin
          send_op(FN_ENQ, rand_value());
          sent++;
        end
        repeat ($urandom_range(1, 3)) begin
          send_op(FN_ENQ, rand_value());
          sent++;
        end
      end else if (kind == 1) begin
        // drain, then pop an empty queue
        while (in_cnt + out_cnt > 0) begin
          send_op(FN_DEQ, rand_value());
          sent++;
        end
        repeat ($urandom_range(1, 3)) begin
          send_op(FN_DEQ, rand_value());
          sent++;
        end
      end else begin
        enq_pct = (kind < 5) ? 70 : (kind < 8) ? 50 : 30;
        len     = $urandom_range(4, 60);
        repeat (len) begin
          send_op(($urandom_range(0, 99) < enq_pct) ? FN_ENQ : FN_DEQ, rand_value());
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    cmd.valid   = 1'b0;
    cmd.func    = FN_ENQ;
    cmd.value   = '0;
    in_cnt      = 0;
    out_cnt     = 0;
    err_count   = 0;
    idle_cycles = 0;
    burst_left  = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    test_empty_dequeue();
    test_extremes();
    test_interleave();
    test_random();
    cmd.valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (QDEPTH + 16) @(posedge clk);

    if (err_count == 0 && pending_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mtq_pkg.sv
rtl/mtq_in_if.sv
rtl/mtq_out_if.sv
rtl/mtq_cell.sv
rtl/mtq_stack.sv
rtl/max_tracking_queue.sv
rtl/mtq_checker.sv
test/tb.sv
